[src/dfmn_pkg.sv]
// ----------------------------------------------------------------------------
// dfmn_pkg
// shared types and constants of the depth frame min/max normalizer
// ----------------------------------------------------------------------------
package dfmn_pkg;

  localparam int CFG_W = 20;
  localparam logic [CFG_W-1:0] FRAME_PIXELS_RESET = 20'd307200;

  localparam int GRAY_W = 8;
  localparam logic [GRAY_W-1:0] GRAY_INVALID = 8'd0;
  localparam logic [GRAY_W-1:0] GRAY_LOW     = 8'd1;
  localparam logic [GRAY_W-1:0] GRAY_HIGH    = 8'd255;
  localparam logic [GRAY_W-1:0] GRAY_ONE     = 8'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic prep;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

[src/depth_frame_minmax_normalizer_core.sv]
// ----------------------------------------------------------------------------
// depth_frame_minmax_normalizer_core
// stores a depth frame and reads it back scaled to 8-bit gray by frame min/max
// ----------------------------------------------------------------------------
// usage:
//   input beats (in_valid/in_stall) carry in_operation and in_depth. a load
//   beat writes one sample and tracks the frame extremes; it gives no output.
//   a read beat returns one out beat with out_gray (0 for no reading, else
//   1..255) and out_last_of_frame on the frame's final pixel.
//   cfg_wr_en/cfg_wr_data set the frame size; write it only while idle.
// flow:
//   loads stream at one per clock while no read is in progress.
//   a read fetches the sample, classifies it, then runs a restoring divider
//   one quotient bit per cycle for DEPTH_BITS+8 quotient bits and hands off
//   the result; in_stall holds off every new beat until that hand-off, and
//   samples that need no division skip the divider.
// reset: positions clear, extremes return to empty, frame size 307200.
//   the sample store is not cleared.
// stall: the result sits in the output register; the next beat is still
//   accepted, and a later read waits in its hand-off step until out is free.
// ----------------------------------------------------------------------------
module depth_frame_minmax_normalizer_core #(
  parameter int MAX_FRAME_PIXELS = 524288,
  parameter int DEPTH_BITS       = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [DEPTH_BITS-1:0]       in_depth,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dfmn_pkg::GRAY_W-1:0] out_gray,
  output logic                        out_last_of_frame,
  input  logic                        cfg_wr_en,
  input  logic [dfmn_pkg::CFG_W-1:0]  cfg_wr_data
);

  dfmn_pkg::dp_cmd_t    cmd;
  dfmn_pkg::dp_status_t status;

  dfmn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  dfmn_datapath #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
    .DEPTH_BITS       (DEPTH_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_depth          (in_depth),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_gray          (out_gray),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

[src/dfmn_ctrl.sv]
// ----------------------------------------------------------------------------
// dfmn_ctrl
// sequencer: takes beats, runs fetch / scale / divide / hand-off of a read
// ----------------------------------------------------------------------------
module dfmn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_operation,
  output logic                 in_stall,
  input  dfmn_pkg::dp_status_t status,
  output dfmn_pkg::dp_cmd_t    cmd
);

  dfmn_pkg::state_t state_r, state_nxt;

  logic accept;

  assign in_stall = (state_r != dfmn_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      dfmn_pkg::S_IDLE: begin
        if (accept) begin
          if (in_operation == dfmn_pkg::OP_READ) begin
            cmd.read  = 1'b1;
            state_nxt = dfmn_pkg::S_PREP;
          end else begin
            cmd.load  = 1'b1;
          end
        end
      end
      dfmn_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = status.special ? dfmn_pkg::S_DONE : dfmn_pkg::S_DIV;
      end
      dfmn_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = dfmn_pkg::S_DONE;
        end
      end
      dfmn_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = dfmn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dfmn_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfmn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/dfmn_datapath.sv]
// ----------------------------------------------------------------------------
// dfmn_datapath
// sample store, frame extremes, position counters, restoring divider, output
// ----------------------------------------------------------------------------
module dfmn_datapath #(
  parameter int MAX_FRAME_PIXELS = 524288,
  parameter int DEPTH_BITS       = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dfmn_pkg::dp_cmd_t           cmd,
  output dfmn_pkg::dp_status_t        status,
  input  logic [DEPTH_BITS-1:0]       in_depth,
  input  logic                        cfg_wr_en,
  input  logic [dfmn_pkg::CFG_W-1:0]  cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dfmn_pkg::GRAY_W-1:0] out_gray,
  output logic                        out_last_of_frame
);

  localparam int PW    = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
  localparam int DW    = DEPTH_BITS;
  localparam int GW    = dfmn_pkg::GRAY_W;
  localparam int NUM_W = DW + GW;
  localparam int CW    = $clog2(NUM_W);
  localparam int EW    = (PW >= dfmn_pkg::CFG_W) ? PW + 1 : dfmn_pkg::CFG_W + 1;
  localparam logic [DW-1:0] NO_READ = {DW{1'b1}};
  localparam logic [EW-1:0] MAX_E   = EW'(MAX_FRAME_PIXELS);

  logic [DW-1:0] store_mem [MAX_FRAME_PIXELS];

  logic [dfmn_pkg::CFG_W-1:0] frame_r;
  logic [PW-1:0]    wr_pos_r, rd_pos_r;
  logic [DW-1:0]    run_min_r, run_max_r, frame_min_r, frame_max_r;
  logic [DW-1:0]    rd_data_r;
  logic             last_r;
  logic [NUM_W-1:0] num_r;
  logic [DW-1:0]    den_r, rem_r;
  logic [CW-1:0]    cnt_r;
  logic             special_r;
  logic [GW-1:0]    spec_val_r;
  logic             out_valid_r, out_last_r;
  logic [GW-1:0]    out_gray_r;

  // effective frame size, clamped to 1..MAX
  logic [EW-1:0] frame_ext, n_eff, n_last;
  logic          wr_last, rd_last;

  always_comb begin
    frame_ext = EW'(frame_r);
    if (frame_r == '0) begin
      n_eff = EW'(1);
    end else if (frame_ext > MAX_E) begin
      n_eff = MAX_E;
    end else begin
      n_eff = frame_ext;
    end
    n_last  = n_eff - EW'(1);
    wr_last = EW'(wr_pos_r) >= n_last;
    rd_last = EW'(rd_pos_r) >= n_last;
  end

  // running extremes including the incoming sample
  logic          d_ok;
  logic [DW-1:0] min_upd, max_upd;

  always_comb begin
    d_ok    = (in_depth != NO_READ);
    min_upd = (d_ok && (in_depth < run_min_r)) ? in_depth : run_min_r;
    max_upd = (d_ok && (in_depth > run_max_r)) ? in_depth : run_max_r;
  end

  // classification of the fetched sample
  logic          is_special;
  logic [GW-1:0] spec_val;
  logic [DW-1:0] diff, span;
  logic [NUM_W-1:0] num_init;

  always_comb begin
    is_special = 1'b1;
    spec_val   = dfmn_pkg::GRAY_LOW;
    if (rd_data_r == NO_READ) begin
      spec_val = dfmn_pkg::GRAY_INVALID;
    end else if (frame_max_r <= frame_min_r) begin
      spec_val = dfmn_pkg::GRAY_LOW;
    end else if (rd_data_r <= frame_min_r) begin
      spec_val = dfmn_pkg::GRAY_LOW;
    end else if (rd_data_r >= frame_max_r) begin
      spec_val = dfmn_pkg::GRAY_HIGH;
    end else begin
      is_special = 1'b0;
    end
    diff = rd_data_r - frame_min_r;
    span = frame_max_r - frame_min_r;
    // times 254 as 256x - 2x
    num_init = (NUM_W'(diff) << GW) - (NUM_W'(diff) << 1);
  end

  // one restoring step per cycle, quotient shifts into num_r
  logic [DW:0]   rem_sh;
  logic [DW+1:0] trial;
  logic          q_bit;

  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_r};
    q_bit  = !trial[DW+1];
  end

  assign status.special  = is_special;
  assign status.div_last = (cnt_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_mem[wr_pos_r] <= in_depth;
    end
    if (cmd.read) begin
      rd_data_r <= store_mem[rd_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      last_r <= rd_last;
    end
    if (cmd.prep) begin
      num_r      <= num_init;
      den_r      <= span;
      rem_r      <= '0;
      cnt_r      <= CW'(NUM_W - 1);
      special_r  <= is_special;
      spec_val_r <= spec_val;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], q_bit};
      rem_r <= q_bit ? trial[DW-1:0] : rem_sh[DW-1:0];
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.out_load) begin
      out_gray_r <= special_r ? spec_val_r : (num_r[GW-1:0] + dfmn_pkg::GRAY_ONE);
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= dfmn_pkg::FRAME_PIXELS_RESET;
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      run_min_r   <= NO_READ;
      run_max_r   <= '0;
      frame_min_r <= NO_READ;
      frame_max_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        if (wr_last) begin
          frame_min_r <= min_upd;
          frame_max_r <= max_upd;
          run_min_r   <= NO_READ;
          run_max_r   <= '0;
          wr_pos_r    <= '0;
        end else begin
          run_min_r <= min_upd;
          run_max_r <= max_upd;
          wr_pos_r  <= wr_pos_r + PW'(1);
        end
      end
      if (cmd.read) begin
        rd_pos_r <= rd_last ? '0 : rd_pos_r + PW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gray          = out_gray_r;
  assign out_last_of_frame = out_last_r;

endmodule
